[hw/rtl/rptg_pkg.sv]
// Shared constants, types and helpers of the ramped pulse train generator.
package rptg_pkg;

    // Field widths
    localparam int TICK_W      = 20;
    localparam int DUR_W       = 16;
    localparam int COUNT_W     = 8;
    localparam int STEP_W      = 10;
    localparam int PHASE_W     = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Sequencer phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TRIG  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ARM   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HIGH  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LOW   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_PAUSE = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_WIDTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_COUNT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_END_PAUSE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_STEP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_HIGH     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LOW      = 3'd5;

    // Values after reset
    localparam logic [DUR_W-1:0]   RST_TRIGGER_WIDTH = 16'd10;
    localparam logic [COUNT_W-1:0] RST_PULSE_COUNT   = 8'd7 + 8'd13;
    localparam logic [DUR_W-1:0]   RST_END_PAUSE     = 16'd500 * 16'd16;
    localparam logic [STEP_W-1:0]  RST_WIDTH_STEP    = 10'd50;
    localparam logic [DUR_W-1:0]   RST_BASE_HIGH     = 16'd100 * 16'd12;
    localparam logic [DUR_W-1:0]   RST_BASE_LOW      = 16'd100 * 16'd1;

    typedef struct packed {
        logic [DUR_W-1:0]   trigger_width;
        logic [COUNT_W-1:0] pulse_count;
        logic [DUR_W-1:0]   end_pause;
        logic [STEP_W-1:0]  width_step;
        logic [DUR_W-1:0]   base_high;
        logic [DUR_W-1:0]   base_low;
    } cfg_t;

    // A zero duration counts as one tick
    function automatic logic [DUR_W-1:0] dur_min1(input logic [DUR_W-1:0] v);
        return (v == '0) ? DUR_W'(1) : v;
    endfunction

    function automatic logic [TICK_W-1:0] tick_min1(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

[hw/rtl/rptg_in_if.sv]
// Tick input channel: valid/ready handshake with the two switch levels.
interface rptg_in_if;
    logic valid;
    logic ready;
    logic on_switch;
    logic invert_switch;

    modport source (output valid, output on_switch, output invert_switch, input ready);
    modport sink   (input valid, input on_switch, input invert_switch, output ready);
endinterface

[hw/rtl/rptg_out_if.sv]
// Result channel: valid/ready handshake with the wave and trigger levels.
interface rptg_out_if;
    logic valid;
    logic ready;
    logic wave_out;
    logic trigger_out;

    modport source (output valid, output wave_out, output trigger_out, input ready);
    modport sink   (input valid, input wave_out, input trigger_out, output ready);
endinterface

[hw/rtl/rptg_cfg_regs.sv]
// Configuration register file of the ramped pulse train generator.
module rptg_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rptg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rptg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rptg_pkg::cfg_t                  cfg
);
    import rptg_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_width <= RST_TRIGGER_WIDTH;
            cfg_reg.pulse_count   <= RST_PULSE_COUNT;
            cfg_reg.end_pause     <= RST_END_PAUSE;
            cfg_reg.width_step    <= RST_WIDTH_STEP;
            cfg_reg.base_high     <= RST_BASE_HIGH;
            cfg_reg.base_low      <= RST_BASE_LOW;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRIGGER_WIDTH: cfg_reg.trigger_width <= cfg_data;
                REG_PULSE_COUNT:   cfg_reg.pulse_count   <= cfg_data[COUNT_W-1:0];
                REG_END_PAUSE:     cfg_reg.end_pause     <= cfg_data;
                REG_WIDTH_STEP:    cfg_reg.width_step    <= cfg_data[STEP_W-1:0];
                REG_BASE_HIGH:     cfg_reg.base_high     <= cfg_data;
                REG_BASE_LOW:      cfg_reg.base_low      <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/ramped_pulse_train_generator.sv]
// Ramped pulse train generator: one tick in, one wave/trigger beat out.
//
//  channel | direction | payload                     | handshake
//  --------+-----------+-----------------------------+------------------
//  in_ch   | in        | on_switch, invert_switch    | valid / ready
//  out_ch  | out       | wave_out, trigger_out       | valid / ready
//  cfg     | in        | cfg_index, cfg_data         | cfg_we, no wait
//
// The sequencer state and the result register update together at the edge
// where the tick beat is accepted, so a tick can be taken every cycle while
// the output is not stalled. The result shows in the cycle after its tick.
// A stalled output holds its beat; a new tick is taken in the same cycle
// as the waiting beat leaves. Reset returns the sequencer to idle, clears
// the result valid and sets the configuration registers to their defaults.
module ramped_pulse_train_generator
(
    input  logic                             clk,
    input  logic                             rst_n,
    rptg_in_if.sink                          in_ch,
    rptg_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [rptg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rptg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rptg_pkg::*;

    cfg_t cfg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TICK_W-1:0]  tick_left_reg, tick_left_next;
    logic [COUNT_W-1:0] pulse_index_reg, pulse_index_next;
    logic [TICK_W-1:0]  current_high_reg, current_high_next;
    logic [DUR_W-1:0]   gap_length_reg, gap_length_next;

    logic               out_valid_reg;
    logic               wave_reg, wave_next;
    logic               trigger_reg, trigger_next;

    // Working values of the tick in progress
    logic [PHASE_W-1:0] ph;
    logic [TICK_W-1:0]  tl;
    logic [TICK_W-1:0]  tl_dec;
    logic [TICK_W-1:0]  high_sum;
    logic [COUNT_W:0]   pulses_done;
    logic [DUR_W-1:0]   arm_high;
    logic [DUR_W-1:0]   arm_low;
    logic               running;
    logic               accept;

    rptg_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;

    assign arm_high     = in_ch.invert_switch ? cfg.base_low  : cfg.base_high;
    assign arm_low      = in_ch.invert_switch ? cfg.base_high : cfg.base_low;
    assign high_sum     = current_high_reg + TICK_W'(cfg.width_step);
    assign pulses_done  = {1'b0, pulse_index_reg} + (COUNT_W+1)'(1);

    // Advance the sequencer by one tick
    always_comb
    begin
        phase_next        = phase_reg;
        tick_left_next    = tick_left_reg;
        pulse_index_next  = pulse_index_reg;
        current_high_next = current_high_reg;
        gap_length_next   = gap_length_reg;
        running           = 1'b1;
        ph                = phase_reg;
        tl                = tick_left_reg;

        if (ph > PH_PAUSE)
        begin
            ph = PH_IDLE;
        end

        // Start a block on an idle tick with the switch on
        if (ph == PH_IDLE)
        begin
            if (!in_ch.on_switch)
            begin
                running = 1'b0;
            end
            else
            begin
                ph = PH_TRIG;
                tl = TICK_W'(dur_min1(cfg.trigger_width));
            end
        end

        // Latch the base times on the first tick after the trigger
        if (ph == PH_ARM)
        begin
            current_high_next = TICK_W'(dur_min1(arm_high));
            gap_length_next   = dur_min1(arm_low);
            pulse_index_next  = '0;
            if (cfg.pulse_count == '0)
            begin
                ph = PH_PAUSE;
                tl = TICK_W'(dur_min1(cfg.end_pause));
            end
            else
            begin
                ph = PH_HIGH;
                tl = current_high_next;
            end
        end

        wave_next    = running && (ph == PH_HIGH);
        trigger_next = running && (ph == PH_TRIG);
        tl_dec       = tick_min1(tl) - TICK_W'(1);

        if (!running)
        begin
            phase_next = PH_IDLE;
        end
        else if (tl_dec != '0)
        begin
            phase_next     = ph;
            tick_left_next = tl_dec;
        end
        else
        begin
            tick_left_next = tl_dec;
            unique case (ph)
                PH_TRIG:
                begin
                    phase_next = PH_ARM;
                end
                PH_HIGH:
                begin
                    phase_next     = PH_LOW;
                    tick_left_next = TICK_W'(dur_min1(gap_length_next));
                end
                PH_LOW:
                begin
                    if (pulses_done >= {1'b0, cfg.pulse_count})
                    begin
                        phase_next     = PH_PAUSE;
                        tick_left_next = TICK_W'(dur_min1(cfg.end_pause));
                    end
                    else
                    begin
                        pulse_index_next  = pulses_done[COUNT_W-1:0];
                        current_high_next = tick_min1(high_sum);
                        phase_next        = PH_HIGH;
                        tick_left_next    = current_high_next;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Hold the sequencer state; step it on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_left_reg    <= '0;
            pulse_index_reg  <= '0;
            current_high_reg <= '0;
            gap_length_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            tick_left_reg    <= tick_left_next;
            pulse_index_reg  <= pulse_index_next;
            current_high_reg <= current_high_next;
            gap_length_reg   <= gap_length_next;
        end
    end

    // Result register: load on a tick beat, drop when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wave_reg    <= wave_next;
            trigger_reg <= trigger_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.wave_out    = wave_reg;
    assign out_ch.trigger_out = trigger_reg;

endmodule

[hw/rtl/rptg_checker.sv]
// Port-level checks of the ramped pulse train generator, bound to the top level.
module rptg_port_checks
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic wave_out,
    input logic trigger_out
);

    // A waiting result beat holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(wave_out) && $stable(trigger_out)))
    else $error("result beat changed while stalled");

    // Trigger and wave never high in the same tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(wave_out && trigger_out))
    else $error("wave and trigger high together");

    // Every accepted tick gives a result beat in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
    else $error("tick accepted without a result beat");

    // With no beat waiting the block takes ticks
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
    else $error("tick input stalled with free result register");

endmodule

bind ramped_pulse_train_generator rptg_port_checks u_rptg_port_checks
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .wave_out    (out_ch.wave_out),
    .trigger_out (out_ch.trigger_out)
);
